// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fir filter check failed");

// Checked on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fir filter check failed");

`endif

// ----- rtl/fir_pkg.sv -----
`default_nettype none
package fir_pkg;

  // Ring length and coefficient table depth
  localparam int TAPS   = 16;
  localparam int ADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CNT_W  = $clog2(TAPS + 1);

  // Field widths
  localparam int WORD_W      = 16;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int OUT_W       = 36;
  localparam int TAP_COUNT_W = 5;
  localparam int COEF_SEL_W  = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT   = 2'd0,
    REG_COEF_SELECT = 2'd1,
    REG_COEF_WORD   = 2'd2
  } fir_reg_t;

  // Tags that travel with each memory read into the MAC pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } fir_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/fir_ram.sv -----
`default_nettype none
// Single-port-write, single-port-read memory with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
module fir_ram
  import fir_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic signed [WORD_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic signed [WORD_W-1:0]      rdata
);

  logic signed [WORD_W-1:0] mem [TAPS];
  logic [TAPS-1:0]          valid;

  // Storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule
`default_nettype wire

// ----- rtl/fir_mac.sv -----
`default_nettype none
// Multiply-accumulate pipeline: tag align, product register, accumulator.
module fir_mac
  import fir_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire fir_ctl_t                 ctl,
  input  wire logic signed [WORD_W-1:0] coef,
  input  wire logic signed [WORD_W-1:0] sample,
  output logic signed [OUT_W-1:0]       acc,
  output logic                          done
);

  fir_ctl_t                 ctl_rd;
  fir_ctl_t                 ctl_mul;
  logic signed [PROD_W-1:0] prod;
  logic signed [OUT_W-1:0]  prod_ext;
  logic signed [OUT_W-1:0]  acc_base;

  // Tags follow the memory latency, then the multiplier stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_rd  <= '0;
      ctl_mul <= '0;
      done    <= 1'b0;
    end else begin
      ctl_rd  <= ctl;
      ctl_mul <= ctl_rd;
      done    <= ctl_mul.valid && ctl_mul.last;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (ctl_rd.valid) begin
      prod <= coef * sample;
    end
  end

  assign prod_ext = OUT_W'(prod);
  assign acc_base = ctl_mul.first ? '0 : acc;

  // Accumulator, restarted by the first tap of each sample
  always_ff @(posedge clk) begin
    if (ctl_mul.valid) begin
      acc <= acc_base + prod_ext;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fir_filter_core.sv -----
`default_nettype none
// FIR filter over a circular sample store, one tap per cycle.
// Input channel: sample_in with sample_valid / sample_ready; a transfer writes
// the sample into the ring at the write position, then the block walks the
// n taps in use (n = tap_count clamped to 1..16), one memory read of sample
// and coefficient per cycle, into a registered multiply and an accumulator.
// Output channel: filtered_out with filtered_valid / filtered_ready, a full
// Q6.30 sum with no rounding.
// The tap walk feeds the registered memory reads, the product register and the
// accumulator in that order; the next sample is taken only once the core is back
// in idle, a limit set by the single read port of each memory feeding one multiplier.
// The output register frees the input: a new sample is taken while a result
// waits; if the receiver stalls past the next sum, that sum holds in the
// accumulator and the input stays closed until the output register drains.
// Configuration: cfg_we with cfg_index / cfg_data, only while idle.
// Reset clears the ring, the coefficient table and the write position,
// sets tap_count to 16 and empties the output register.
module fir_filter_core
  import fir_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic signed [WORD_W-1:0]    sample_in,
  input  wire logic                        sample_valid,
  output logic                             sample_ready,
  output logic signed [OUT_W-1:0]          filtered_out,
  output logic                             filtered_valid,
  input  wire logic                        filtered_ready,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_HOLD} state_t;

  state_t                   state;
  logic [TAP_COUNT_W-1:0]   tap_count;
  logic [COEF_SEL_W-1:0]    coef_select;
  logic [CNT_W-1:0]         n_use;
  logic [ADDR_W-1:0]        wp;
  logic [ADDR_W-1:0]        pos;
  logic [ADDR_W-1:0]        wp_next;
  logic [ADDR_W-1:0]        k;
  logic [ADDR_W-1:0]        j;
  logic [ADDR_W-1:0]        j_next;
  logic                     k_last;
  logic                     take;
  logic                     out_free;
  logic                     out_load;
  logic                     coef_we;
  fir_ctl_t                 ctl;
  logic signed [WORD_W-1:0] coef_rd;
  logic signed [WORD_W-1:0] sample_rd;
  logic signed [OUT_W-1:0]  acc;
  logic                     mac_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count   <= TAP_COUNT_W'(TAPS);
      coef_select <= '0;
    end else if (cfg_we) begin
      case (fir_reg_t'(cfg_index))
        REG_TAP_COUNT:   tap_count   <= cfg_data[TAP_COUNT_W-1:0];
        REG_COEF_SELECT: coef_select <= cfg_data[COEF_SEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign coef_we = cfg_we && (fir_reg_t'(cfg_index) == REG_COEF_WORD)
                   && (int'(coef_select) < TAPS);

  // Taps in use: zero acts as one, anything above the table as full depth
  always_comb begin
    if (tap_count == '0) begin
      n_use = CNT_W'(1);
    end else if (int'(tap_count) > TAPS) begin
      n_use = CNT_W'(TAPS);
    end else begin
      n_use = CNT_W'(tap_count);
    end
  end

  // Write position, forced to zero if stale after tap_count was lowered
  assign pos     = (CNT_W'(wp) >= n_use) ? '0 : wp;
  assign wp_next = ((CNT_W'(pos) + CNT_W'(1)) >= n_use) ? '0 : pos + ADDR_W'(1);
  assign j_next  = ((CNT_W'(j) + CNT_W'(1)) >= n_use) ? '0 : j + ADDR_W'(1);
  assign k_last  = (CNT_W'(k) == (n_use - CNT_W'(1)));

  assign sample_ready = (state == S_IDLE);
  assign take         = sample_valid && sample_ready;
  assign out_free     = !filtered_valid || filtered_ready;
  assign out_load     = out_free && (((state == S_WAIT) && mac_done) || (state == S_HOLD));

  // Read tags for the MAC pipeline
  always_comb begin
    ctl.valid = (state == S_RUN);
    ctl.first = (k == '0);
    ctl.last  = k_last;
  end

  // Sequencer, tap counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      wp             <= '0;
      k              <= '0;
      j              <= '0;
      filtered_valid <= 1'b0;
    end else begin
      if (out_load) begin
        filtered_out   <= acc;
        filtered_valid <= 1'b1;
      end else if (filtered_valid && filtered_ready) begin
        filtered_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            wp    <= wp_next;
            k     <= '0;
            j     <= pos;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          k <= k + ADDR_W'(1);
          j <= j_next;
          if (k_last) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mac_done) begin
            if (out_load) begin
              state <= S_IDLE;
            end else begin
              state <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sample ring: written on transfer, read by the tap walk
  fir_ram u_ring (
    .clk   (clk),
    .rst   (rst),
    .we    (take),
    .waddr (pos),
    .wdata (sample_in),
    .raddr (j),
    .rdata (sample_rd)
  );

  // Coefficient table: written from the configuration port
  fir_ram u_coef (
    .clk   (clk),
    .rst   (rst),
    .we    (coef_we),
    .waddr (ADDR_W'(coef_select)),
    .wdata (signed'(cfg_data[WORD_W-1:0])),
    .raddr (k),
    .rdata (coef_rd)
  );

  fir_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .coef   (coef_rd),
    .sample (sample_rd),
    .acc    (acc),
    .done   (mac_done)
  );

endmodule
`default_nettype wire

// ----- rtl/fir_chk.sv -----
`default_nettype none
`include "assert_macros.svh"
// Port-level checks for the FIR core.
module fir_chk
  import fir_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     sample_valid,
  input wire logic                     sample_ready,
  input wire logic signed [OUT_W-1:0]  filtered_out,
  input wire logic                     filtered_valid,
  input wire logic                     filtered_ready
);

  // A stalled result holds
  `CHK_ASSERT(a_out_hold, clk, rst, filtered_valid && !filtered_ready |=> filtered_valid && $stable(filtered_out))

  // After a sample transfer the core is busy walking taps
  `CHK_ASSERT(a_busy_after_take, clk, rst, sample_valid && sample_ready |=> !sample_ready)

  // A fresh result is loaded only as the core returns to idle
  `CHK_ASSERT(a_result_at_idle, clk, rst, $rose(filtered_valid) |-> sample_ready)

  // Reset leaves the core idle with no result pending
  `CHK_ASSERT_ALWAYS(a_reset_state, clk, rst |=> sample_ready && !filtered_valid)

endmodule

bind fir_filter_core fir_chk u_fir_chk (.*);
`default_nettype wire
